FILE: hdl/vfc_pkg.sv
// shared constants, types and codes for the voxel face culling block
`timescale 1ns / 1ps

package vfc_pkg;

    // chunk geometry
    localparam int EDGE_CELLS = 16;
    localparam int CELL_COUNT = EDGE_CELLS * EDGE_CELLS * EDGE_CELLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // word field widths
    localparam int ID_W       = 8;
    localparam int COORD_W    = 4;
    localparam int NCOORD_W   = COORD_W + 1;
    localparam int FACE_COUNT = 6;
    localparam int STEP_W     = 3;

    typedef logic [ID_W-1:0]       t_id;
    typedef logic [COORD_W-1:0]    t_coord;
    typedef logic [NCOORD_W-1:0]   t_ncoord;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [FACE_COUNT-1:0] t_mask;
    typedef logic [STEP_W-1:0]     t_step;

    // operation codes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // read sequence of a query: own cell first, then one neighbour per face
    localparam t_step STEP_HERE = 3'd0;
    localparam t_step STEP_NZ   = 3'd1;
    localparam t_step STEP_PZ   = 3'd2;
    localparam t_step STEP_NX   = 3'd3;
    localparam t_step STEP_PX   = 3'd4;
    localparam t_step STEP_NY   = 3'd5;
    localparam t_step STEP_PY   = 3'd6;
    localparam t_step STEP_LAST = STEP_PY;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_PUSH
    } t_state;

endpackage

FILE: hdl/vfc_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps

module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/voxel_face_culling.sv
// voxel face culling top level: voxel store, query sequencer and output register
// a write word is stored while idle; a query reads its cell and six neighbours through
// the single ram port, one read per cycle, then passes the drain and push states,
// and the next word is taken once its result is loaded into the output register
// after reset the store is swept to air, one cell a cycle (4096 cells for a
// 16-cell edge), and no word is taken until the sweep is done
`timescale 1ns / 1ps

module voxel_face_culling (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  vfc_pkg::t_coord       i_pos_x,
    input  vfc_pkg::t_coord       i_pos_y,
    input  vfc_pkg::t_coord       i_pos_z,
    input  vfc_pkg::t_id          i_new_id,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output vfc_pkg::t_id          o_cell_id,
    output vfc_pkg::t_coord       o_out_x,
    output vfc_pkg::t_coord       o_out_y,
    output vfc_pkg::t_coord       o_out_z,
    output vfc_pkg::t_mask        o_face_mask
);

    import vfc_pkg::*;

    function automatic t_addr cell_addr(t_ncoord x, t_ncoord y, t_ncoord z);
        t_addr a;
        a = (ADDR_W'(x) * ADDR_W'(EDGE_CELLS) + ADDR_W'(y)) * ADDR_W'(EDGE_CELLS)
            + ADDR_W'(z);
        return a;
    endfunction

    t_state  r_state, n_state;
    t_addr   r_clr_addr, n_clr_addr;
    t_step   r_step, n_step;
    t_coord  r_qx, r_qy, r_qz;
    logic    r_chk_vld;
    t_step   r_chk_step;
    logic    r_chk_in;
    t_id     r_here;
    t_mask   r_mask;
    logic    r_out_vld;
    t_id     r_out_id;
    t_coord  r_out_x, r_out_y, r_out_z;
    t_mask   r_out_mask;

    logic    ram_we;
    t_addr   ram_addr;
    t_id     ram_wdata;
    t_id     ram_rdata;

    logic    in_acc;
    logic    out_free;
    logic    wr_inside;
    t_ncoord nb_x, nb_y, nb_z;
    logic    nb_neg;
    logic    nb_inside;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;

    // write target check
    assign wr_inside = (int'(i_pos_x) < EDGE_CELLS) && (int'(i_pos_y) < EDGE_CELLS) &&
                       (int'(i_pos_z) < EDGE_CELLS);

    // coordinate of the cell read in the current step
    always_comb begin
        nb_x   = {1'b0, r_qx};
        nb_y   = {1'b0, r_qy};
        nb_z   = {1'b0, r_qz};
        nb_neg = 1'b0;
        case (r_step)
            STEP_NZ: begin
                nb_neg = (r_qz == '0);
                nb_z   = {1'b0, r_qz} - NCOORD_W'(1);
            end
            STEP_PZ: begin
                nb_z = {1'b0, r_qz} + NCOORD_W'(1);
            end
            STEP_NX: begin
                nb_neg = (r_qx == '0);
                nb_x   = {1'b0, r_qx} - NCOORD_W'(1);
            end
            STEP_PX: begin
                nb_x = {1'b0, r_qx} + NCOORD_W'(1);
            end
            STEP_NY: begin
                nb_neg = (r_qy == '0);
                nb_y   = {1'b0, r_qy} - NCOORD_W'(1);
            end
            STEP_PY: begin
                nb_y = {1'b0, r_qy} + NCOORD_W'(1);
            end
            default: begin
                nb_neg = 1'b0;
            end
        endcase
        nb_inside = !nb_neg && (int'(nb_x) < EDGE_CELLS) && (int'(nb_y) < EDGE_CELLS) &&
                    (int'(nb_z) < EDGE_CELLS);
    end

    // sequencer next state and ram port
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_step     = r_step;
        ram_we     = 1'b0;
        ram_addr   = cell_addr(nb_x, nb_y, nb_z);
        ram_wdata  = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ram_addr  = cell_addr({1'b0, i_pos_x}, {1'b0, i_pos_y}, {1'b0, i_pos_z});
                ram_wdata = i_new_id;
                if (in_acc) begin
                    if (i_op == OP_QUERY) begin
                        n_step  = STEP_HERE;
                        n_state = ST_READ;
                    end else begin
                        ram_we = wr_inside;
                    end
                end
            end
            ST_READ: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_step     <= STEP_HERE;
            r_chk_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_step     <= n_step;
            r_chk_vld  <= (r_state == ST_READ);
        end
    end

    // query capture and read tracking
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_qx <= i_pos_x;
            r_qy <= i_pos_y;
            r_qz <= i_pos_z;
        end
        r_chk_step <= r_step;
        r_chk_in   <= nb_inside;
    end

    // collect own id and face bits as read data returns
    always_ff @(posedge i_clk) begin
        if (r_chk_vld) begin
            if (r_chk_step == STEP_HERE) begin
                r_here <= r_chk_in ? ram_rdata : '0;
            end
            for (int f = 0; f < FACE_COUNT; f++) begin
                if (r_chk_step == STEP_W'(f + 1)) begin
                    r_mask[f] <= !(r_chk_in && (ram_rdata != '0));
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == ST_PUSH) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_PUSH) && out_free) begin
            r_out_id   <= r_here;
            r_out_x    <= r_qx;
            r_out_y    <= r_qy;
            r_out_z    <= r_qz;
            r_out_mask <= (r_here != '0) ? r_mask : '0;
        end
    end

    // voxel store
    vfc_ram #(
        .WIDTH(ID_W),
        .DEPTH(CELL_COUNT)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cell_id   = r_out_id;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_face_mask = r_out_mask;

`ifndef ASSERT_OFF
    // the store is only written by the sweep or by an accepted write word
    a_we_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR) || (in_acc && (i_op == OP_WRITE)))
        else $error("voxel store written outside sweep or write word");

    // an accepted query starts its read sequence at the own cell
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_op == OP_QUERY)) |=> (r_state == ST_READ) && (r_step == STEP_HERE))
        else $error("query did not start its read sequence");

    // a new result only appears after the push state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_PUSH))
        else $error("result appeared without a finished query");

    // returning read data always belongs to one of the seven steps
    a_chk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> (r_chk_step <= STEP_LAST))
        else $error("read data tagged with an unknown step");
`endif

endmodule
